[rtl/bdsn_pkg.sv]
package bdsn_pkg;

	// Geometry of the hash set.
	localparam int ROW_BITS   = 6;
	localparam int SLOTS      = 32;
	localparam int TABLE_W    = 2;
	localparam int TABLES     = 3;
	localparam int TABLE_ROWS = 1 << ROW_BITS;
	localparam int ALL_ROWS   = TABLES * TABLE_ROWS;
	localparam int ALL_SLOTS  = ALL_ROWS * SLOTS;

	// Widths.
	localparam int HASH_W      = 64;
	localparam int SEL_W       = 8;
	localparam int STATUS_W    = 2;
	localparam int LIMIT_W     = 6;
	localparam int ROW_W       = ROW_BITS + TABLE_W;
	localparam int FILL_W      = $clog2(SLOTS + 1);
	localparam int ADDR_W      = (ALL_SLOTS > 1) ? $clog2(ALL_SLOTS) : 1;
	localparam int CMP_W       = ((FILL_W > LIMIT_W) ? FILL_W : LIMIT_W) + 1;
	localparam int IN_TDATA_W  = 2 * HASH_W;
	localparam int OUT_TDATA_W = 8;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20);

	// Table select codes.
	localparam logic [SEL_W-1:0] TBL_TITLE  = SEL_W'(1);
	localparam logic [SEL_W-1:0] TBL_AUTHOR = SEL_W'(2);
	localparam logic [SEL_W-1:0] TBL_FIRST  = SEL_W'(3);

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED,
		ST_DUPLICATE,
		ST_ROW_FULL,
		ST_BAD_TABLE
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FILL,
		S_SCAN,
		S_FINISH
	} state_t;

	// Request to the row fill table.
	typedef struct packed {
		logic              rd_en;
		logic [ROW_W-1:0]  rd_row;
		logic              wr_en;
		logic [ROW_W-1:0]  wr_row;
		logic [FILL_W-1:0] wr_fill;
	} fill_req_t;

	// Request to the slot memory; data holds {mh, h}.
	typedef struct packed {
		logic                  rd_en;
		logic [ADDR_W-1:0]     rd_addr;
		logic                  wr_en;
		logic [ADDR_W-1:0]     wr_addr;
		logic [2*HASH_W-1:0]   wr_data;
	} slot_req_t;

endpackage

[rtl/bdsn_ram.sv]
module bdsn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/bdsn_fill.sv]
module bdsn_fill (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bdsn_pkg::fill_req_t       req,
	output logic [bdsn_pkg::FILL_W-1:0] rdata
);

	import bdsn_pkg::*;

	logic [ALL_ROWS-1:0] valid_q;
	logic                vld_s1;
	logic [FILL_W-1:0]   ram_rdata;

	// Fill counts live in a small RAM; a row never written reads as empty.
	bdsn_ram #(
		.WIDTH (FILL_W),
		.DEPTH (ALL_ROWS)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.wr_row),
		.wdata (req.wr_fill),
		.re    (req.rd_en),
		.raddr (req.rd_row),
		.rdata (ram_rdata)
	);

	// Per-row valid bits, cleared at reset and set on the first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_row] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_s1 <= valid_q[req.rd_row];
			end
		end
	end

	assign rdata = vld_s1 ? ram_rdata : '0;

endmodule

[rtl/bdsn_ctrl.sv]
module bdsn_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bdsn_pkg::SEL_W-1:0]    in_sel,
	input  logic [bdsn_pkg::HASH_W-1:0]   in_h,
	input  logic [bdsn_pkg::HASH_W-1:0]   in_mh,
	input  logic [bdsn_pkg::LIMIT_W-1:0]  limit,
	output bdsn_pkg::fill_req_t           fill_req,
	input  logic [bdsn_pkg::FILL_W-1:0]   fill_rdata,
	output bdsn_pkg::slot_req_t           slot_req,
	input  logic [2*bdsn_pkg::HASH_W-1:0] slot_rdata,
	input  logic                          res_ready,
	output logic                          res_valid,
	output bdsn_pkg::status_t             res_status
);

	import bdsn_pkg::*;

	state_t             state_q, state_d;
	logic [HASH_W-1:0]  h_q, mh_q;
	logic [ROW_W-1:0]   row_q;
	logic [ADDR_W-1:0]  base_q;
	logic [FILL_W-1:0]  fill_q, idx_q, same_q;
	logic               rd_valid_s1;
	status_t            status_q;

	logic               accept, sel_ok, issue, hit_h, dup, scan_done;
	logic [TABLE_W-1:0] tbl;
	logic [ROW_W-1:0]   row_in;
	logic [FILL_W-1:0]  fill_eff;
	logic [CMP_W-1:0]   same_next;

	assign accept = in_valid && in_ready;
	assign sel_ok = (in_sel == TBL_TITLE) || (in_sel == TBL_AUTHOR) || (in_sel == TBL_FIRST);
	assign tbl    = TABLE_W'(in_sel[TABLE_W-1:0] - TABLE_W'(1));
	assign row_in = {tbl, in_h[HASH_W-1 -: ROW_BITS]};

	// A stored count is never above the row size.
	assign fill_eff = (fill_rdata > FILL_W'(SLOTS)) ? FILL_W'(SLOTS) : fill_rdata;

	// Scan: one slot read issued per cycle, compared when its data returns.
	assign issue     = (state_q == S_SCAN) && (idx_q < fill_q);
	assign hit_h     = rd_valid_s1 && (slot_rdata[HASH_W-1:0] == h_q);
	assign same_next = CMP_W'(same_q) + CMP_W'(1);
	assign dup       = hit_h && ((same_next >= CMP_W'(limit))
		|| (slot_rdata[2*HASH_W-1:HASH_W] == mh_q));
	assign scan_done = !issue && !rd_valid_s1;

	// Next state and memory requests.
	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		res_valid        = 1'b0;
		res_status       = status_q;
		fill_req         = '0;
		fill_req.rd_row  = row_in;
		fill_req.wr_row  = row_q;
		fill_req.wr_fill = FILL_W'(fill_q + FILL_W'(1));
		slot_req         = '0;
		slot_req.rd_en   = issue;
		slot_req.rd_addr = ADDR_W'(base_q + ADDR_W'(idx_q));
		slot_req.wr_addr = ADDR_W'(base_q + ADDR_W'(fill_q));
		slot_req.wr_data = {mh_q, h_q};
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					fill_req.rd_en = sel_ok;
					state_d        = sel_ok ? S_FILL : S_FINISH;
				end
			end
			S_FILL: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (dup || scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (res_ready) begin
					res_valid = 1'b1;
					if (status_q == ST_INSERTED) begin
						slot_req.wr_en = 1'b1;
						fill_req.wr_en = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue && !dup;
		end
	end

	// Item payload, row pointers and scan counters.
	always_ff @(posedge clk) begin
		if (accept) begin
			h_q      <= in_h;
			mh_q     <= in_mh;
			row_q    <= row_in;
			status_q <= ST_BAD_TABLE;
		end
		if (state_q == S_FILL) begin
			fill_q <= fill_eff;
			base_q <= ADDR_W'(ADDR_W'(row_q) * ADDR_W'(SLOTS));
			idx_q  <= '0;
			same_q <= '0;
		end
		if (issue) begin
			idx_q <= FILL_W'(idx_q + FILL_W'(1));
		end
		if (hit_h) begin
			same_q <= FILL_W'(same_next);
		end
		if (state_q == S_SCAN) begin
			if (dup) begin
				status_q <= ST_DUPLICATE;
			end else if (scan_done) begin
				status_q <= (fill_q == FILL_W'(SLOTS)) ? ST_ROW_FULL : ST_INSERTED;
			end
		end
	end

`ifndef ASSERT_OFF
	a_idx_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= fill_q) && (fill_q <= FILL_W'(SLOTS)))
		else $error("scan index ran past the row fill");

	a_same_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (same_q <= idx_q))
		else $error("same-h count exceeds slots read");

	a_no_rd_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(slot_req.rd_en && slot_req.wr_en))
		else $error("slot memory read and write in one cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("block idle right after taking a request");
`endif

endmodule

[rtl/bucketed_dedup_set_with_near_limit_unit.sv]
// Bucketed duplicate filter over three tables of (h, mh) hash pairs.
// Input stream: s_axis_tuser carries the table select, s_axis_tdata the two
// hashes. A request is taken when s_axis_tvalid and s_axis_tready are high.
// Output stream: one status per request on m_axis_tdata, in request order:
// inserted, duplicate, row full or bad table select.
// Configuration: near_dup_limit_we writes near_dup_limit_wdata into the
// near-duplicate limit; write it only while no request is in flight.
// Sequence: a request occupies the block from acceptance until its status is
// handed to the output register; the scan covers the stored slots of its
// row, and a duplicate ends the scan early.
// The scan reads one stored slot per cycle from the single read port of the
// slot memory. A bad table select skips the fill lookup and the scan. Once
// the scan ends, the sequencer passes the status to the output register
// when that register is free.
// Reset clears all row fill counts at once; the slot memory keeps no reset
// state and is only read below a row's fill count. The near-duplicate limit
// resets to 20.
// Stalls: a new request is taken while an earlier status waits in the output
// register; the block holds its finished status until that register is empty or m_axis_tready frees it.
module bucketed_dedup_set_with_near_limit_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// key_h [63:0], key_mh [127:64]
	input  logic [bdsn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// table_select [7:0]
	input  logic [bdsn_pkg::SEL_W-1:0]          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// status [1:0], zeros above
	output logic [bdsn_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                near_dup_limit_we,
	input  logic [bdsn_pkg::LIMIT_W-1:0]        near_dup_limit_wdata
);

	import bdsn_pkg::*;

	logic [LIMIT_W-1:0]  limit_q;
	logic                out_valid_q;
	status_t             out_status_q;
	fill_req_t           fill_req;
	logic [FILL_W-1:0]   fill_rdata;
	slot_req_t           slot_req;
	logic [2*HASH_W-1:0] slot_rdata;
	logic                res_ready, res_valid;
	status_t             res_status;

	// Near-duplicate limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (near_dup_limit_we) begin
			limit_q <= near_dup_limit_wdata;
		end
	end

	// Sequencer for lookup, scan and write-back.
	bdsn_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_sel     (s_axis_tuser),
		.in_h       (s_axis_tdata[HASH_W-1:0]),
		.in_mh      (s_axis_tdata[2*HASH_W-1:HASH_W]),
		.limit      (limit_q),
		.fill_req   (fill_req),
		.fill_rdata (fill_rdata),
		.slot_req   (slot_req),
		.slot_rdata (slot_rdata),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.res_status (res_status)
	);

	// Row fill counts.
	bdsn_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fill_req),
		.rdata  (fill_rdata)
	);

	// Stored (h, mh) pairs, one row of slots per table row.
	bdsn_ram #(
		.WIDTH (2 * HASH_W),
		.DEPTH (ALL_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (slot_req.wr_en),
		.waddr (slot_req.wr_addr),
		.wdata (slot_req.wr_data),
		.re    (slot_req.rd_en),
		.raddr (slot_req.rd_addr),
		.rdata (slot_rdata)
	);

	// Output register between the sequencer and the receiver.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_status_q <= res_status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_status_q);

endmodule
